/* design/dcmbx_pkg.sv */
// Package for the dual processor mailbox FIFO.
// Holds command codes, control register bit masks, FSM state and the
// controller-to-datapath command struct. No dependencies.
package dcmbx_pkg;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_CTRL = 2'd2,
    CMD_NONE = 2'd3
  } dcmbx_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } dcmbx_state_t;

  typedef struct packed {
    logic accept;
    logic load;
  } dcmbx_cmd_t;

  localparam int CTRL_BITS = 16;

  localparam logic [15:0] B_SEND_EMPTY   = 16'h0001;
  localparam logic [15:0] B_SEND_FULL    = 16'h0002;
  localparam logic [15:0] B_SEND_IRQ     = 16'h0004;
  localparam logic [15:0] B_SEND_CLEAR   = 16'h0008;
  localparam logic [15:0] B_RECV_EMPTY   = 16'h0100;
  localparam logic [15:0] B_RECV_FULL    = 16'h0200;
  localparam logic [15:0] B_RECV_IRQ     = 16'h0400;
  localparam logic [15:0] B_ERROR        = 16'h4000;
  localparam logic [15:0] B_ENABLE       = 16'h8000;
  localparam logic [15:0] B_WRITABLE     = 16'h8404;
  localparam logic [15:0] KEEP_SEND_SIDE = 16'hBFFC;
  localparam logic [15:0] KEEP_RECV_SIDE = 16'hBCFF;
  localparam logic [15:0] CTRL_RESET     = 16'h0101;

  localparam int PORT_WORD_BITS = 32;

endpackage

/* design/dual_cpu_mailbox_fifo.sv */
// Top level of the dual processor mailbox FIFO.
// Instantiates dcmbx_ctrl and dcmbx_dp; depends on dcmbx_pkg.
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------------------------
//   in      | in_valid / in_ready   | in_command, in_side, in_data_word
//   out     | out_valid / out_ready | out_read_word, out_local_control,
//           |                       | out_remote_control, out_irq_side,
//           |                       | out_irq_send_empty, out_irq_recv_nonempty
//
// Each beat is accepted in ST_IDLE (state update, RAM access), then waits in ST_READ
// for the registered RAM read, after which the result loads the output register.
// A new beat is accepted while a finished result waits on the output.
// The result load waits while the output register is full and not taken.
// Reset is synchronous: both control registers return to 0x0101, queues empty.
module dual_cpu_mailbox_fifo #(
  parameter int FIFO_DEPTH = 16,
  parameter int WORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic        in_side,
  input  logic [31:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_word,
  output logic [15:0] out_local_control,
  output logic [15:0] out_remote_control,
  output logic        out_irq_side,
  output logic        out_irq_send_empty,
  output logic        out_irq_recv_nonempty
);
  import dcmbx_pkg::*;

  dcmbx_cmd_t cmd;

  dcmbx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dcmbx_dp #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_command            (in_command),
    .in_side               (in_side),
    .in_data_word          (in_data_word),
    .out_read_word         (out_read_word),
    .out_local_control     (out_local_control),
    .out_remote_control    (out_remote_control),
    .out_irq_side          (out_irq_side),
    .out_irq_send_empty    (out_irq_send_empty),
    .out_irq_recv_nonempty (out_irq_recv_nonempty)
  );

endmodule

/* design/dcmbx_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dcmbx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/dcmbx_ctrl.sv */
// Controller FSM for the mailbox: accepts a beat, waits for RAM read data,
// loads the output register. Depends on dcmbx_pkg.
module dcmbx_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output dcmbx_pkg::dcmbx_cmd_t  cmd
);
  import dcmbx_pkg::*;

  dcmbx_state_t state_r, state_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic         can_load;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ: begin
        cmd.load = can_load;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/dcmbx_dp.sv */
// Mailbox datapath: per-side pointers, fill counts and control registers,
// the shared word RAM and the output register. Depends on dcmbx_pkg, dcmbx_ram.
module dcmbx_dp #(
  parameter int FIFO_DEPTH = 16,
  parameter int WORD_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dcmbx_pkg::dcmbx_cmd_t cmd,
  input  logic [1:0]            in_command,
  input  logic                  in_side,
  input  logic [31:0]           in_data_word,
  output logic [31:0]           out_read_word,
  output logic [15:0]           out_local_control,
  output logic [15:0]           out_remote_control,
  output logic                  out_irq_side,
  output logic                  out_irq_send_empty,
  output logic                  out_irq_recv_nonempty
);
  import dcmbx_pkg::*;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int RAM_D  = 2 * FIFO_DEPTH;
  localparam int ADDR_W = $clog2(RAM_D);

  typedef struct packed {
    logic [PTR_W-1:0]     rp;
    logic [PTR_W-1:0]     wp;
    logic [CNT_W-1:0]     cnt;
    logic [CTRL_BITS-1:0] ctrl;
  } side_t;

  side_t s0_r, s0_nxt, s1_r, s1_nxt;
  side_t me, oth, me_n, oth_n;

  logic [15:0]          cl, cr, v;
  logic [CNT_W-1:0]     cnt_inc, cnt_dec;
  logic                 pop_ok, irq_to, p_send, p_recv;
  logic                 ram_we, ram_re;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [WORD_BITS-1:0] wdata, rdata;
  logic [31:0]          rd_ext;

  logic                 pop_ok_r;
  logic [15:0]          lc_r, rc_r;
  logic                 irq_to_r, p_send_r, p_recv_r;

  logic [31:0]          out_read_word_r;
  logic [15:0]          out_local_control_r, out_remote_control_r;
  logic                 out_irq_side_r, out_irq_send_empty_r, out_irq_recv_nonempty_r;

  generate
    if (WORD_BITS > PORT_WORD_BITS) begin : g_wide
      assign wdata  = {{(WORD_BITS - PORT_WORD_BITS){1'b0}}, in_data_word};
      assign rd_ext = rdata[PORT_WORD_BITS-1:0];
    end else if (WORD_BITS == PORT_WORD_BITS) begin : g_equal
      assign wdata  = in_data_word;
      assign rd_ext = rdata;
    end else begin : g_narrow
      assign wdata  = in_data_word[WORD_BITS-1:0];
      assign rd_ext = {{(PORT_WORD_BITS - WORD_BITS){1'b0}}, rdata};
    end
  endgenerate

  assign me      = in_side ? s1_r : s0_r;
  assign oth     = in_side ? s0_r : s1_r;
  assign cnt_inc = me.cnt + CNT_W'(1);
  assign cnt_dec = oth.cnt - CNT_W'(1);
  assign v       = in_data_word[15:0];
  assign waddr   = in_side ? ADDR_W'(FIFO_DEPTH) + ADDR_W'(me.wp) : ADDR_W'(me.wp);
  assign raddr   = in_side ? ADDR_W'(oth.rp) : ADDR_W'(FIFO_DEPTH) + ADDR_W'(oth.rp);

  always_comb begin
    me_n   = me;
    oth_n  = oth;
    cl     = me.ctrl;
    cr     = oth.ctrl;
    pop_ok = 1'b0;
    irq_to = 1'b0;
    p_send = 1'b0;
    p_recv = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    unique case (in_command)
      CMD_PUSH: begin
        if ((cl & B_ENABLE) != '0) begin
          if (me.cnt >= CNT_W'(FIFO_DEPTH)) begin
            cl = cl | B_ERROR;
          end else begin
            cl      = cl & KEEP_SEND_SIDE;
            cr      = cr & KEEP_RECV_SIDE;
            ram_we  = 1'b1;
            me_n.wp = (me.wp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : me.wp + PTR_W'(1);
            me_n.cnt = cnt_inc;
            if (cnt_inc >= CNT_W'(FIFO_DEPTH)) begin
              cl = cl | B_SEND_FULL;
              cr = cr | B_RECV_FULL;
            end
            if ((cr & B_RECV_IRQ) != '0) begin
              p_recv = 1'b1;
              irq_to = ~in_side;
            end
          end
        end
      end
      CMD_POP: begin
        if ((cl & B_ENABLE) != '0) begin
          if (oth.cnt == '0) begin
            cl = cl | B_ERROR;
          end else begin
            cl        = cl & KEEP_RECV_SIDE;
            cr        = cr & KEEP_SEND_SIDE;
            ram_re    = 1'b1;
            pop_ok    = 1'b1;
            oth_n.rp  = (oth.rp == PTR_W'(FIFO_DEPTH - 1)) ? '0 : oth.rp + PTR_W'(1);
            oth_n.cnt = cnt_dec;
            if (cnt_dec == '0) begin
              cl = cl | B_RECV_EMPTY;
              cr = cr | B_SEND_EMPTY;
              if ((cr & B_SEND_IRQ) != '0) begin
                p_send = 1'b1;
                irq_to = ~in_side;
              end
            end
          end
        end
      end
      CMD_CTRL: begin
        if ((v & B_ERROR) != '0) cl = cl & ~B_ERROR;
        if ((v & B_SEND_CLEAR) != '0) begin
          me_n.rp  = '0;
          me_n.wp  = '0;
          me_n.cnt = '0;
          cl = (cl | B_SEND_EMPTY) & ~B_SEND_FULL;
          cr = (cr | B_RECV_EMPTY) & ~B_RECV_FULL;
        end
        cl = (cl & ~B_WRITABLE) | (v & B_WRITABLE);
        if ((cl & B_SEND_IRQ) != '0 && (cl & B_SEND_EMPTY) != '0) begin
          p_send = 1'b1;
          irq_to = in_side;
        end
        if ((cl & B_RECV_IRQ) != '0 && (cl & B_RECV_EMPTY) == '0) begin
          p_recv = 1'b1;
          irq_to = in_side;
        end
      end
      default: ;
    endcase
    me_n.ctrl  = cl;
    oth_n.ctrl = cr;
  end

  always_comb begin
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    if (cmd.accept) begin
      s0_nxt = in_side ? oth_n : me_n;
      s1_nxt = in_side ? me_n : oth_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '{rp: '0, wp: '0, cnt: '0, ctrl: CTRL_RESET};
      s1_r <= '{rp: '0, wp: '0, cnt: '0, ctrl: CTRL_RESET};
    end else begin
      s0_r <= s0_nxt;
      s1_r <= s1_nxt;
    end
  end

  dcmbx_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_D)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.accept && ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.accept && ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pop_ok_r <= pop_ok;
      lc_r     <= cl;
      rc_r     <= cr;
      irq_to_r <= irq_to;
      p_send_r <= p_send;
      p_recv_r <= p_recv;
    end
    if (cmd.load) begin
      out_read_word_r         <= pop_ok_r ? rd_ext : '0;
      out_local_control_r     <= lc_r;
      out_remote_control_r    <= rc_r;
      out_irq_side_r          <= irq_to_r;
      out_irq_send_empty_r    <= p_send_r;
      out_irq_recv_nonempty_r <= p_recv_r;
    end
  end

  assign out_read_word         = out_read_word_r;
  assign out_local_control     = out_local_control_r;
  assign out_remote_control    = out_remote_control_r;
  assign out_irq_side          = out_irq_side_r;
  assign out_irq_send_empty    = out_irq_send_empty_r;
  assign out_irq_recv_nonempty = out_irq_recv_nonempty_r;

endmodule

/* design/dcmbx_chk.sv */
// Port-level checker for the mailbox FIFO, bound to the top level.
// Depends only on the top level's ports.
module dcmbx_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_word,
  input logic [15:0] out_local_control,
  input logic        out_irq_side,
  input logic        out_irq_send_empty,
  input logic        out_irq_recv_nonempty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_word))
    else $error("stalled result beat changed");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while one is in flight");

  a_irq_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_irq_send_empty && !out_irq_recv_nonempty |-> !out_irq_side)
    else $error("irq side set without a pulse");

  a_pop_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_word != 32'd0 |-> !out_local_control[14])
    else $error("error flag set on a successful pop");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_local_control[0] && out_local_control[1]))
    else $error("send empty and send full both set");

endmodule

bind dual_cpu_mailbox_fifo dcmbx_chk u_dcmbx_chk (.*);

/* sim/dcmbx_checker.sv */
// Mailbox checker: predicts each access of the dual processor mailbox FIFO and
// compares every result beat, field by field, with the oldest prediction.
// Depends on dcmbx_pkg for command codes and control register bit masks.
`timescale 1ns / 1ps

module dcmbx_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic        in_side,
  input  logic [31:0] in_data_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_read_word,
  input  logic [15:0] out_local_control,
  input  logic [15:0] out_remote_control,
  input  logic        out_irq_side,
  input  logic        out_irq_send_empty,
  input  logic        out_irq_recv_nonempty,
  output int          fail_count,
  output int          pending,
  output int          n_beats,
  output int          n_stored,
  output int          n_popped,
  output int          n_errors,
  output int          n_irqs
);
  import dcmbx_pkg::*;

  localparam int MBX_DEPTH = 16;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [31:0] read_word;
    logic [15:0] local_ctrl;
    logic [15:0] remote_ctrl;
    logic        irq_side;
    logic        irq_send_empty;
    logic        irq_recv_nonempty;
  } mbx_result_t;

  logic [31:0] mb_word [0:1][0:MBX_DEPTH-1];
  logic [3:0]  rd_ptr [0:1];
  logic [3:0]  wr_ptr [0:1];
  logic [4:0]  fill [0:1];
  logic [15:0] ctrl [0:1];

  mbx_result_t expected_results[$];

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < MAX_REPORTS)
      $display("MISMATCH at %0t, %s: got %h, expected %h", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic predict_access(input dcmbx_op_t op, input logic me,
                                input logic [31:0] data, output mbx_result_t r);
    logic        other;
    logic [15:0] cl;
    logic [15:0] cr;
    logic [15:0] v;
    other = ~me;
    cl = ctrl[me];
    cr = ctrl[other];
    r = '0;
    case (op)
      CMD_PUSH: begin
        if ((cl & B_ENABLE) != 0) begin
          if (fill[me] >= MBX_DEPTH) begin
            cl |= B_ERROR;
            n_errors++;
          end else begin
            cl &= KEEP_SEND_SIDE;
            cr &= KEEP_RECV_SIDE;
            mb_word[me][wr_ptr[me]] = data;
            wr_ptr[me] = wr_ptr[me] + 4'd1;
            fill[me] = fill[me] + 5'd1;
            n_stored++;
            if (fill[me] >= MBX_DEPTH) begin
              cl |= B_SEND_FULL;
              cr |= B_RECV_FULL;
            end
            if ((cr & B_RECV_IRQ) != 0) begin
              r.irq_recv_nonempty = 1'b1;
              r.irq_side = other;
            end
          end
        end
      end
      CMD_POP: begin
        if ((cl & B_ENABLE) != 0) begin
          if (fill[other] == 0) begin
            cl |= B_ERROR;
            n_errors++;
          end else begin
            cl &= KEEP_RECV_SIDE;
            cr &= KEEP_SEND_SIDE;
            r.read_word = mb_word[other][rd_ptr[other]];
            rd_ptr[other] = rd_ptr[other] + 4'd1;
            fill[other] = fill[other] - 5'd1;
            n_popped++;
            if (fill[other] == 0) begin
              cl |= B_RECV_EMPTY;
              cr |= B_SEND_EMPTY;
              if ((cr & B_SEND_IRQ) != 0) begin
                r.irq_send_empty = 1'b1;
                r.irq_side = other;
              end
            end
          end
        end
      end
      CMD_CTRL: begin
        v = data[15:0];
        if ((v & B_ERROR) != 0) cl &= ~B_ERROR;
        if ((v & B_SEND_CLEAR) != 0) begin
          rd_ptr[me] = '0;
          wr_ptr[me] = '0;
          fill[me] = '0;
          cl |= B_SEND_EMPTY;
          cr |= B_RECV_EMPTY;
          cl &= ~B_SEND_FULL;
          cr &= ~B_RECV_FULL;
        end
        cl = (cl & ~B_WRITABLE) | (v & B_WRITABLE);
        if ((cl & B_SEND_IRQ) != 0 && (cl & B_SEND_EMPTY) != 0) begin
          r.irq_send_empty = 1'b1;
          r.irq_side = me;
        end
        if ((cl & B_RECV_IRQ) != 0 && (cl & B_RECV_EMPTY) == 0) begin
          r.irq_recv_nonempty = 1'b1;
          r.irq_side = me;
        end
      end
      default: ;
    endcase
    ctrl[me] = cl;
    ctrl[other] = cr;
    r.local_ctrl = cl;
    r.remote_ctrl = cr;
    n_irqs += r.irq_send_empty + r.irq_recv_nonempty;
  endtask

  always @(posedge clk) begin : monitor
    mbx_result_t want;
    mbx_result_t got;
    if (!rst_n) begin
      for (int s = 0; s < 2; s++) begin
        rd_ptr[s] = '0;
        wr_ptr[s] = '0;
        fill[s] = '0;
        ctrl[s] = CTRL_RESET;
      end
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_access(dcmbx_op_t'(in_command), in_side, in_data_word, want);
        expected_results.push_back(want);
        n_beats++;
      end
      if (out_valid && out_ready) begin
        got.read_word = out_read_word;
        got.local_ctrl = out_local_control;
        got.remote_ctrl = out_remote_control;
        got.irq_side = out_irq_side;
        got.irq_send_empty = out_irq_send_empty;
        got.irq_recv_nonempty = out_irq_recv_nonempty;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected, read_word", got.read_word, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.read_word !== want.read_word)
            report_mismatch("read_word", got.read_word, want.read_word);
          if (got.local_ctrl !== want.local_ctrl)
            report_mismatch("local_control", 32'(got.local_ctrl), 32'(want.local_ctrl));
          if (got.remote_ctrl !== want.remote_ctrl)
            report_mismatch("remote_control", 32'(got.remote_ctrl), 32'(want.remote_ctrl));
          if (got.irq_side !== want.irq_side)
            report_mismatch("irq_side", 32'(got.irq_side), 32'(want.irq_side));
          if (got.irq_send_empty !== want.irq_send_empty)
            report_mismatch("irq_send_empty", 32'(got.irq_send_empty),
                            32'(want.irq_send_empty));
          if (got.irq_recv_nonempty !== want.irq_recv_nonempty)
            report_mismatch("irq_recv_nonempty", 32'(got.irq_recv_nonempty),
                            32'(want.irq_recv_nonempty));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

/* sim/tb.sv */
// Testbench top for dual_cpu_mailbox_fifo: drives directed and random bus
// accesses under several idling mixes and gives the verdict.
// Depends on dcmbx_pkg, the mailbox RTL and dcmbx_checker.
`timescale 1ns / 1ps

module tb;
  import dcmbx_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic        in_side;
  logic [31:0] in_data_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_word;
  logic [15:0] out_local_control;
  logic [15:0] out_remote_control;
  logic        out_irq_side;
  logic        out_irq_send_empty;
  logic        out_irq_recv_nonempty;

  int fail_count;
  int pending;
  int n_beats;
  int n_stored;
  int n_popped;
  int n_errors;
  int n_irqs;

  int sender_idle_pct;
  int stall_pct;
  int idle_cycles;

  dual_cpu_mailbox_fifo dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_side               (in_side),
    .in_data_word          (in_data_word),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_read_word         (out_read_word),
    .out_local_control     (out_local_control),
    .out_remote_control    (out_remote_control),
    .out_irq_side          (out_irq_side),
    .out_irq_send_empty    (out_irq_send_empty),
    .out_irq_recv_nonempty (out_irq_recv_nonempty)
  );

  dcmbx_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_side               (in_side),
    .in_data_word          (in_data_word),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_read_word         (out_read_word),
    .out_local_control     (out_local_control),
    .out_remote_control    (out_remote_control),
    .out_irq_side          (out_irq_side),
    .out_irq_send_empty    (out_irq_send_empty),
    .out_irq_recv_nonempty (out_irq_recv_nonempty),
    .fail_count            (fail_count),
    .pending               (pending),
    .n_beats               (n_beats),
    .n_stored              (n_stored),
    .n_popped              (n_popped),
    .n_errors              (n_errors),
    .n_irqs                (n_irqs)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Hold valid and payload until accepted; optionally idle first.
  task automatic send_beat(input dcmbx_op_t op, input logic s, input logic [31:0] d);
    int gap;
    gap = 0;
    while (gap < 6 && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= op;
    in_side <= s;
    in_data_word <= d;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait for every predicted result to drain.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] random_ctrl_word(input bit force_on);
    logic [31:0] w;
    w = $urandom;
    w[15] = force_on || ($urandom_range(9) != 0);
    w[3] = ($urandom_range(6) == 0);
    return w;
  endfunction

  task automatic run_phase(input int idle_pct, input int stall_in, input int n_items);
    int   sent;
    int   pick;
    int   len;
    logic s;
    sender_idle_pct = idle_pct;
    stall_pct = stall_in;
    sent = 0;
    send_beat(CMD_CTRL, 1'b0, random_ctrl_word(1'b1));
    send_beat(CMD_CTRL, 1'b1, random_ctrl_word(1'b1));
    while (sent < n_items) begin
      pick = $urandom_range(99);
      s = 1'($urandom_range(1));
      len = $urandom_range(1, 18);
      if (pick < 35) begin
        repeat (len) begin
          send_beat(CMD_PUSH, s, $urandom);
          sent++;
        end
      end else if (pick < 70) begin
        repeat (len) begin
          send_beat(CMD_POP, s, $urandom);
          sent++;
        end
      end else if (pick < 85) begin
        send_beat(CMD_CTRL, s, random_ctrl_word(1'b0));
        sent++;
      end else begin
        repeat (len % 5 + 1) begin
          send_beat(dcmbx_op_t'($urandom_range(2)), 1'($urandom_range(1)), $urandom);
          sent++;
        end
      end
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_PUSH;
    in_side = 1'b0;
    in_data_word = '0;
    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Accesses before enable, error set and acknowledge, fill to full and
    // overflow, pop of the oldest word, clear of a nonempty queue, disable.
    send_beat(CMD_POP, 1'b0, 32'h1234_5678);
    send_beat(CMD_PUSH, 1'b1, 32'hA5A5_5A5A);
    send_beat(CMD_CTRL, 1'b0, {16'h0000, B_WRITABLE});
    send_beat(CMD_CTRL, 1'b1, {16'hFFFF, B_WRITABLE | B_ERROR | B_SEND_CLEAR});
    send_beat(CMD_POP, 1'b0, 32'h0);
    send_beat(CMD_CTRL, 1'b0, {16'h0000, B_WRITABLE | B_ERROR});
    send_beat(CMD_PUSH, 1'b0, 32'hFFFF_FFFF);
    send_beat(CMD_PUSH, 1'b0, 32'h0000_0000);
    repeat (14) send_beat(CMD_PUSH, 1'b0, $urandom);
    send_beat(CMD_PUSH, 1'b0, $urandom);
    send_beat(CMD_POP, 1'b1, 32'h0);
    send_beat(CMD_CTRL, 1'b0, {16'h0000, B_ENABLE | B_SEND_CLEAR});
    send_beat(CMD_CTRL, 1'b0, 32'h0000_0000);
    drain_results();

    run_phase(0, 0, 250);
    run_phase(47, 0, 250);
    run_phase(0, 47, 250);
    run_phase(37, 37, 250);

    stall_pct = 0;
    repeat (20) @(negedge clk);

    $display("Covered %0d accesses over four idling mixes: %0d words stored, %0d popped,",
             n_beats, n_stored, n_popped);
    $display("%0d full/empty errors flagged, %0d interrupt pulses predicted.",
             n_errors, n_irqs);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/dcmbx_pkg.sv
design/dcmbx_ram.sv
design/dcmbx_ctrl.sv
design/dcmbx_dp.sv
design/dual_cpu_mailbox_fifo.sv
design/dcmbx_chk.sv
sim/dcmbx_checker.sv
sim/tb.sv
